@@ design/wum_pkg.sv @@
// ----------------------------------------------------------------------------
// wum_pkg
// shared types and constants for the windowed utilization monitor
// ----------------------------------------------------------------------------
`default_nettype none

package wum_pkg;

    localparam int MAX_RECORDS_DEF = 64;

    localparam logic [31:0] MIN_WINDOW_RESET = 32'd1000;
    localparam logic [6:0]  ROUND_PERCENT    = 7'd100;

    // busy * 100 + total / 2 stays below 2**39
    localparam int NUM_W  = 39;
    // percent never exceeds 100, so seven quotient bits suffice
    localparam int PCT_W  = 7;
    localparam int STEP_W = $clog2(PCT_W);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(PCT_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_CHECK,
        ST_WINDOW,
        ST_VALID,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accum;      // add accepted record to snapshot sums
        logic delta;      // form deltas, move baseline, clear snapshot
        logic window;     // add deltas into window
        logic close;      // take window totals, clear window
        logic diff;       // busy = total - idle
        logic mul;        // numerator and divider start
        logic div_step;   // one restoring division step
        logic emit;       // load output registers
        logic emit_fresh; // fresh flag for the loaded result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;       // void snapshot or fewer than two records
        logic baseline;   // no baseline yet
        logic reject;     // zero total or idle above total
        logic short_win;  // window below threshold
        logic div_last;   // final division step
    } status_t;

endpackage

`default_nettype wire

@@ design/wum_datapath.sv @@
// ----------------------------------------------------------------------------
// wum_datapath
// snapshot sums, baseline, window accumulators and the percent divider
// ----------------------------------------------------------------------------
`default_nettype none

module wum_datapath #(
    parameter int MAX_RECORDS = wum_pkg::MAX_RECORDS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire [31:0]                  cfg_min_window,
    input  wire [31:0]                  run_time,
    input  wire                         is_idle,
    input  wire                         snapshot_ok,
    input  wire wum_pkg::cmd_t          cmd,
    output wum_pkg::status_t            status,
    output logic [wum_pkg::PCT_W-1:0]   percent,
    output logic                        fresh
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);

    logic [31:0]                  min_window_reg;
    logic [31:0]                  snap_total_reg;
    logic [31:0]                  snap_idle_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         ok_reg;
    logic [31:0]                  prev_total_reg;
    logic [31:0]                  prev_idle_reg;
    logic [31:0]                  win_total_reg;
    logic [31:0]                  win_idle_reg;
    logic [31:0]                  d_total_reg;
    logic [31:0]                  d_idle_reg;
    logic [31:0]                  busy_reg;
    logic [wum_pkg::NUM_W-1:0]    num_reg;
    logic [wum_pkg::PCT_W-1:0]    quot_reg;
    logic [wum_pkg::STEP_W-1:0]   step_reg;
    logic [wum_pkg::PCT_W-1:0]    held_reg;

    logic [wum_pkg::NUM_W-1:0]    div_shift;
    logic                         div_fit;
    logic [wum_pkg::PCT_W-1:0]    quot_next;

    assign div_shift = wum_pkg::NUM_W'(d_total_reg) << step_reg;
    assign div_fit   = num_reg >= div_shift;

    always_comb
    begin
        quot_next = quot_reg;
        quot_next[step_reg] = div_fit;
    end

    assign status.skip      = !ok_reg || (count_reg < CNT_MIN);
    assign status.baseline  = (prev_total_reg == 32'd0);
    assign status.reject    = (d_total_reg == 32'd0) || (d_idle_reg > d_total_reg);
    assign status.short_win = (win_total_reg < min_window_reg);
    assign status.div_last  = (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_window_reg <= wum_pkg::MIN_WINDOW_RESET;
            snap_total_reg <= '0;
            snap_idle_reg  <= '0;
            count_reg      <= '0;
            ok_reg         <= 1'b0;
            prev_total_reg <= '0;
            prev_idle_reg  <= '0;
            win_total_reg  <= '0;
            win_idle_reg   <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_window_reg <= cfg_min_window;
            end
            if (cmd.accum)
            begin
                ok_reg <= snapshot_ok;
                if (count_reg < CNT_MAX)
                begin
                    snap_total_reg <= snap_total_reg + run_time;
                    if (is_idle)
                    begin
                        snap_idle_reg <= snap_idle_reg + run_time;
                    end
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.delta)
            begin
                snap_total_reg <= '0;
                snap_idle_reg  <= '0;
                count_reg      <= '0;
                if (!status.skip)
                begin
                    prev_total_reg <= snap_total_reg;
                    prev_idle_reg  <= snap_idle_reg;
                end
            end
            if (cmd.window)
            begin
                win_total_reg <= win_total_reg + d_total_reg;
                win_idle_reg  <= win_idle_reg + d_idle_reg;
            end
            if (cmd.close)
            begin
                win_total_reg <= '0;
                win_idle_reg  <= '0;
            end
            if (cmd.div_step && status.div_last)
            begin
                held_reg <= quot_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.delta)
        begin
            d_total_reg <= snap_total_reg - prev_total_reg;
            d_idle_reg  <= snap_idle_reg - prev_idle_reg;
        end
        if (cmd.close)
        begin
            d_total_reg <= win_total_reg;
            d_idle_reg  <= win_idle_reg;
        end
        if (cmd.diff)
        begin
            busy_reg <= d_total_reg - d_idle_reg;
        end
        if (cmd.mul)
        begin
            num_reg  <= wum_pkg::NUM_W'(busy_reg) * wum_pkg::NUM_W'(wum_pkg::ROUND_PERCENT)
                        + wum_pkg::NUM_W'(d_total_reg >> 1);
            quot_reg <= '0;
            step_reg <= wum_pkg::STEP_FIRST;
        end
        if (cmd.div_step)
        begin
            if (div_fit)
            begin
                num_reg <= num_reg - div_shift;
            end
            quot_reg <= quot_next;
            step_reg <= step_reg - wum_pkg::STEP_W'(1);
        end
        if (cmd.emit)
        begin
            percent <= held_reg;
            fresh   <= cmd.emit_fresh;
        end
    end

endmodule

`default_nettype wire

@@ design/wum_controller.sv @@
// ----------------------------------------------------------------------------
// wum_controller
// sequences snapshot close-out, division and the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module wum_controller (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 last_record,
    output logic                out_valid,
    input  wire                 out_ready,
    input  wire wum_pkg::status_t status,
    output wum_pkg::cmd_t       cmd
);

    wum_pkg::state_t state_reg;
    wum_pkg::state_t state_next;
    logic            fresh_reg;
    logic            fresh_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            in_fire;
    logic            slot_free;

    assign in_ready  = (state_reg == wum_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wum_pkg::ST_IDLE;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.emit_fresh = fresh_reg;
        case (state_reg)
            wum_pkg::ST_IDLE:
            begin
                cmd.accum = in_fire;
                if (in_fire && last_record)
                begin
                    state_next = wum_pkg::ST_DELTA;
                end
            end
            wum_pkg::ST_DELTA:
            begin
                cmd.delta  = 1'b1;
                fresh_next = 1'b0;
                if (status.skip || status.baseline)
                begin
                    state_next = wum_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = wum_pkg::ST_CHECK;
                end
            end
            wum_pkg::ST_CHECK:
            begin
                if (status.reject)
                begin
                    state_next = wum_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.window = 1'b1;
                    state_next = wum_pkg::ST_WINDOW;
                end
            end
            wum_pkg::ST_WINDOW:
            begin
                if (status.short_win)
                begin
                    state_next = wum_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.close  = 1'b1;
                    state_next = wum_pkg::ST_VALID;
                end
            end
            wum_pkg::ST_VALID:
            begin
                if (status.reject)
                begin
                    state_next = wum_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.diff   = 1'b1;
                    state_next = wum_pkg::ST_MUL;
                end
            end
            wum_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = wum_pkg::ST_DIV;
            end
            wum_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    fresh_next = 1'b1;
                    state_next = wum_pkg::ST_EMIT;
                end
            end
            wum_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wum_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wum_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/windowed_utilization_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_utilization_monitor_unit
// busy percentage from snapshots of per-task cumulative run-time counters
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    run_time, is_idle, last_record, snapshot_ok
//  output    out_valid / out_ready  percent, fresh
//  config    cfg_valid / cfg_ready  cfg_min_window
//
//  records that are not last are taken back to back
//  a last record is followed by close-out, which reports the held value or
//  divides out a new percent in seven restoring steps of the divider, then
//  the result beat
//  a waiting result beat does not stop non-last records; a new last record
//  waits in close-out until the output register is free
//  reset clears all sums, baseline, window and held percent; min_window = 1000
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_utilization_monitor_unit #(
    parameter int MAX_RECORDS = wum_pkg::MAX_RECORDS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    // task record beats
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire [31:0]                  run_time,
    input  wire                         is_idle,
    input  wire                         last_record,
    input  wire                         snapshot_ok,
    // result beats
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [wum_pkg::PCT_W-1:0]   percent,
    output logic                        fresh,
    // threshold register write
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire [31:0]                  cfg_min_window
);

    wum_pkg::cmd_t    cmd;
    wum_pkg::status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // state machine: handshakes and close-out sequence
    wum_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .last_record (last_record),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // sums, window, divider and output registers
    wum_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_min_window (cfg_min_window),
        .run_time       (run_time),
        .is_idle        (is_idle),
        .snapshot_ok    (snapshot_ok),
        .cmd            (cmd),
        .status         (status),
        .percent        (percent),
        .fresh          (fresh)
    );

endmodule

`default_nettype wire
